// ===== rtl/rgb2yuv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_pkg
// Shared types, constants and arithmetic helpers for the RGB to YUV 4:2:0
// converter.
// ----------------------------------------------------------------------------
package rgb2yuv_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int DATA_W    = 3 * PIX_W;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;

  localparam int QUEUE_DEPTH = 4;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // BT.601 weights, scaled by 1000
  localparam int PROD_W = 18;
  localparam logic [9:0] COEF_R  = 10'd299;
  localparam logic [9:0] COEF_G  = 10'd587;
  localparam logic [9:0] COEF_B  = 10'd114;
  localparam logic [9:0] COEF_CU = 10'd564;
  localparam logic [9:0] COEF_CV = 10'd713;

  localparam logic [9:0] CHROMA_OFS = 10'd128;
  localparam logic [9:0] SAT_MAX    = 10'd255;

  // x / 1000 as x * ceil(2^28 / 1000) >> 28, exact for x below 2^18
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = 19;
  localparam int MUL_W       = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;

  // one pixel as handed from the front end to the arithmetic pipe
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             chroma;
    logic             last;
  } pix_item_t;

  function automatic logic [PIX_W-1:0] div1000(input logic [PROD_W-1:0] x);
    logic [MUL_W-1:0] p;
    p = MUL_W'(x) * MUL_W'(RECIP_1000);
    return p[RECIP_SHIFT +: PIX_W];
  endfunction

endpackage

// ===== rtl/rgb2yuv_front.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_front
// Input side: size registers, raster position counters and classification
// of each pixel beat (chroma site, last of frame) before it is queued.
// ----------------------------------------------------------------------------
module rgb2yuv_front
  import rgb2yuv_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DATA_W-1:0]    s_axis_tdata,
  output logic                 push,
  output pix_item_t            push_item,
  input  logic                 full
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CMPC_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int CMPR_W = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;

  logic [CMPC_W-1:0] width_ext;
  logic [CMPR_W-1:0] height_ext;
  logic [CMPC_W-1:0] last_col;
  logic [CMPR_W-1:0] last_row;
  logic              row_last;
  logic              frame_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_wdata;
        REG_IMAGE_HEIGHT: image_height <= cfg_wdata;
      endcase
    end
  end

  // last position, with sizes clamped to 2..MAX
  always_comb begin
    width_ext  = CMPC_W'(image_width);
    height_ext = CMPR_W'(image_height);
    if (width_ext < CMPC_W'(2)) begin
      last_col = CMPC_W'(1);
    end else if (width_ext > CMPC_W'(MAX_WIDTH)) begin
      last_col = CMPC_W'(MAX_WIDTH - 1);
    end else begin
      last_col = width_ext - CMPC_W'(1);
    end
    if (height_ext < CMPR_W'(2)) begin
      last_row = CMPR_W'(1);
    end else if (height_ext > CMPR_W'(MAX_HEIGHT)) begin
      last_row = CMPR_W'(MAX_HEIGHT - 1);
    end else begin
      last_row = height_ext - CMPR_W'(1);
    end
  end

  assign row_last   = CMPC_W'(column_count) >= last_col;
  assign frame_last = row_last && (CMPR_W'(row_count) >= last_row);

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    push_item.red    = s_axis_tdata[0 +: PIX_W];
    push_item.green  = s_axis_tdata[PIX_W +: PIX_W];
    push_item.blue   = s_axis_tdata[2*PIX_W +: PIX_W];
    push_item.chroma = !column_count[0] && !row_count[0];
    push_item.last   = frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (push) begin
      if (frame_last) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (row_last) begin
        column_count <= '0;
        row_count    <= row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

endmodule

// ===== rtl/rgb2yuv_fifo.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_fifo
// Short queue of classified pixels between the front end and the pipe.
// ----------------------------------------------------------------------------
module rgb2yuv_fifo
  import rgb2yuv_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pix_item_t push_item,
  output logic      full,
  input  logic      pop,
  output pix_item_t pop_item,
  output logic      empty
);

  localparam int AW = $clog2(DEPTH);

  pix_item_t     mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full     = count == (AW + 1)'(DEPTH);
  assign empty    = count == '0;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW + 1)'(1);
      end
    end
  end

endmodule

// ===== rtl/rgb2yuv_back.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_back
// Arithmetic pipe: weighted luma sum, divide by 1000, chroma differences,
// second divide, offset and saturation into the output register.
// ----------------------------------------------------------------------------
module rgb2yuv_back
  import rgb2yuv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  pix_item_t         in_item,
  output logic              in_ready,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,
  output logic              m_axis_tuser,
  output logic              m_axis_tlast
);

  logic advance;

  // stage 1: weighted sum
  logic              v1;
  logic [PROD_W-1:0] sum1;
  logic [PIX_W-1:0]  red1, blue1;
  logic              chroma1, last1;

  // stage 2: luma
  logic              v2;
  logic [PIX_W-1:0]  y2, red2, blue2;
  logic              chroma2, last2;

  // stage 3: scaled chroma magnitudes
  logic              v3;
  logic [PIX_W-1:0]  y3;
  logic [PROD_W-1:0] mu3, mv3;
  logic              neg_u3, neg_v3, chroma3, last3;

  // stage 4: chroma quotients
  logic              v4;
  logic [PIX_W-1:0]  y4, qu4, qv4;
  logic              neg_u4, neg_v4, chroma4, last4;

  logic [PIX_W:0]    du, dv;
  logic [PIX_W-1:0]  mag_u, mag_v;
  logic [9:0]        tu, tv;
  logic [PIX_W-1:0]  u_sat, v_sat;

  // the whole pipe moves in lockstep, held while the output beat waits
  assign advance  = !m_axis_tvalid || m_axis_tready;
  assign in_ready = advance;

  always_comb begin
    du    = {1'b0, blue2} - {1'b0, y2};
    dv    = {1'b0, red2} - {1'b0, y2};
    mag_u = du[PIX_W] ? PIX_W'(-du) : du[PIX_W-1:0];
    mag_v = dv[PIX_W] ? PIX_W'(-dv) : dv[PIX_W-1:0];
  end

  // 10-bit two's complement, U spans -15..271 and V -53..309 after offset
  always_comb begin
    tu = neg_u4 ? CHROMA_OFS - 10'(qu4) : CHROMA_OFS + 10'(qu4);
    tv = neg_v4 ? CHROMA_OFS - 10'(qv4) : CHROMA_OFS + 10'(qv4);
    if (tu[9]) begin
      u_sat = '0;
    end else if (tu > SAT_MAX) begin
      u_sat = '1;
    end else begin
      u_sat = tu[PIX_W-1:0];
    end
    if (tv[9]) begin
      v_sat = '0;
    end else if (tv > SAT_MAX) begin
      v_sat = '1;
    end else begin
      v_sat = tv[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      v4            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      v1            <= in_valid;
      v2            <= v1;
      v3            <= v2;
      v4            <= v3;
      m_axis_tvalid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sum1    <= PROD_W'(COEF_R) * PROD_W'(in_item.red)
               + PROD_W'(COEF_G) * PROD_W'(in_item.green)
               + PROD_W'(COEF_B) * PROD_W'(in_item.blue);
      red1    <= in_item.red;
      blue1   <= in_item.blue;
      chroma1 <= in_item.chroma;
      last1   <= in_item.last;

      y2      <= div1000(sum1);
      red2    <= red1;
      blue2   <= blue1;
      chroma2 <= chroma1;
      last2   <= last1;

      y3      <= y2;
      mu3     <= PROD_W'(mag_u) * PROD_W'(COEF_CU);
      mv3     <= PROD_W'(mag_v) * PROD_W'(COEF_CV);
      neg_u3  <= du[PIX_W];
      neg_v3  <= dv[PIX_W];
      chroma3 <= chroma2;
      last3   <= last2;

      y4      <= y3;
      qu4     <= div1000(mu3);
      qv4     <= div1000(mv3);
      neg_u4  <= neg_u3;
      neg_v4  <= neg_v3;
      chroma4 <= chroma3;
      last4   <= last3;

      m_axis_tdata <= {chroma4 ? v_sat : PIX_W'(0), chroma4 ? u_sat : PIX_W'(0), y4};
      m_axis_tuser <= chroma4;
      m_axis_tlast <= last4;
    end
  end

endmodule

// ===== rtl/rgb_to_yuv420_converter_core.sv =====
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_core
// BT.601 RGB to YUV 4:2:0 stream converter.
// ----------------------------------------------------------------------------
// Input beats carry one RGB pixel in raster order on s_axis (tdata: red,
// green, blue from the low byte up). Every beat produces one output beat on
// m_axis: tdata holds luma, chroma_u, chroma_v from the low byte up, tuser
// is chroma_valid (set at even row and even column, U and V are zero
// otherwise) and tlast marks the last pixel of the frame.
// Frame size comes from two registers on the write port (cfg_wen,
// cfg_index, cfg_wdata); sizes are clamped to 2..MAX at use. Write them only
// while the converter holds no pixels.
// An accepted beat passes through the queue, then the four-stage arithmetic
// pipe and the output register to m_axis; while m_axis is not stalled the
// pipe takes one pixel per cycle, so throughput is one beat per cycle.
// A stall on m_axis freezes the pipe; the four-entry queue in front of it
// keeps taking pixels until full, then s_axis_tready drops.
// Synchronous reset empties the queue and pipe, returns the position
// counters to the top-left pixel and loads 640x480.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter_core
  import rgb2yuv_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DATA_W-1:0]    s_axis_tdata,  // red, green, blue
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DATA_W-1:0]    m_axis_tdata,  // luma, chroma_u, chroma_v
  output logic                 m_axis_tuser,  // chroma_valid
  output logic                 m_axis_tlast   // frame_end
);

  logic      push, full, pop, empty, back_ready;
  pix_item_t push_item, pop_item;

  rgb2yuv_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .push         (push),
    .push_item    (push_item),
    .full         (full)
  );

  rgb2yuv_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (full),
    .pop      (pop),
    .pop_item (pop_item),
    .empty    (empty)
  );

  assign pop = back_ready && !empty;

  rgb2yuv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (!empty),
    .in_item      (pop_item),
    .in_ready     (back_ready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

// ===== rtl/rgb2yuv_checker.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_checker
// Port-level checks on the converter output stream, bound to the top level.
// ----------------------------------------------------------------------------
module rgb2yuv_checker
  import rgb2yuv_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic              m_axis_tuser,
  input logic              m_axis_tlast
);

  logic after_last;

  // set between a frame's last beat and the first beat of the next frame
  always_ff @(posedge clk) begin
    if (rst) begin
      after_last <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      after_last <= m_axis_tlast;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output beat valid right after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_no_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[DATA_W-1:PIX_W] == '0)
    else $error("U/V nonzero on a pixel without chroma");

  a_frame_start_chroma: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && after_last |-> m_axis_tuser)
    else $error("first pixel of a frame carries no chroma");

endmodule

bind rgb_to_yuv420_converter_core rgb2yuv_checker u_rgb2yuv_checker (.*);

// ===== dv/tb_rgb_to_yuv420_converter_core.sv =====
// ----------------------------------------------------------------------------
// tb_rgb_to_yuv420_converter_core
// Self-checking bench for the RGB to YUV 4:2:0 stream converter.
// ----------------------------------------------------------------------------
// Pixels go in on s_axis with random gaps, results are drained on m_axis with
// random stalls. A scoreboard model tracks the frame position and the size
// registers, predicts luma, chroma and the frame-end mark of every pixel and
// compares each output beat in order. Directed tests cover color extremes,
// resizing in the middle of a row, clamped sizes and an odd width. These
// are followed by random frames of many sizes.
// ----------------------------------------------------------------------------
module tb_rgb_to_yuv420_converter_core;
  import rgb2yuv_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_u;
    logic [PIX_W-1:0] chroma_v;
    logic             chroma_valid;
    logic             frame_end;
  } yuv_beat_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata;   // red, green, blue
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [DATA_W-1:0]    m_axis_tdata;   // luma, chroma_u, chroma_v
  logic                 m_axis_tuser;   // chroma_valid
  logic                 m_axis_tlast;   // frame_end

  // scoreboard state
  yuv_beat_t        pending_yuv[$];
  yuv_beat_t        want;
  logic [CFG_W-1:0] size_width;
  logic [CFG_W-1:0] size_height;
  int               col_pos;
  int               row_pos;
  int               mismatches;
  int               beat_index;
  bit               src_idle;
  bit               sink_idle;

  rgb_to_yuv420_converter_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH: %s", what);
    mismatches++;
  endtask

  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
    if (int'(v) < 2) return 2;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic logic [PIX_W-1:0] sat8(input int v);
    if (v < 0) return '0;
    if (v > 255) return 8'd255;
    return PIX_W'(v);
  endfunction

  // expected output for one pixel; advances the frame position
  function automatic yuv_beat_t predict_yuv(input logic [PIX_W-1:0] r, g, b);
    int        w;
    int        h;
    int        y;
    bit        row_end;
    yuv_beat_t res;
    w = clamp_dim(size_width, DEF_MAX_WIDTH);
    h = clamp_dim(size_height, DEF_MAX_HEIGHT);
    y = (299 * int'(r) + 587 * int'(g) + 114 * int'(b)) / 1000;
    res.luma         = PIX_W'(y);
    res.chroma_valid = (col_pos % 2 == 0) && (row_pos % 2 == 0);
    res.chroma_u     = '0;
    res.chroma_v     = '0;
    if (res.chroma_valid) begin
      // SV int division truncates toward zero, as needed here
      res.chroma_u = sat8((int'(b) - y) * 564 / 1000 + 128);
      res.chroma_v = sat8((int'(r) - y) * 713 / 1000 + 128);
    end
    row_end       = col_pos >= w - 1;
    res.frame_end = row_end && (row_pos >= h - 1);
    if (res.frame_end) begin
      col_pos = 0;
      row_pos = 0;
    end else if (row_end) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
    return res;
  endfunction

  // called at a falling edge, returns at a falling edge; tvalid stays high
  task automatic send_pixel(input logic [PIX_W-1:0] r, g, b);
    int gap;
    gap = src_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    do @(posedge clk); while (!s_axis_tready);
    pending_yuv.push_back(predict_yuv(r, g, b));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    int n;
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    for (n = 0; n < 4000 && pending_yuv.size() != 0; n++) @(negedge clk);
    // pipe is five deep; let it settle before going on
    repeat (8) @(negedge clk);
  endtask

  task automatic set_frame_size(input int w, input int h);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_wdata <= CFG_W'(w);
    @(negedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_wdata <= CFG_W'(h);
    @(negedge clk);
    cfg_wen <= 1'b0;
    size_width  = CFG_W'(w);
    size_height = CFG_W'(h);
    @(negedge clk);
  endtask

  function automatic logic [PIX_W-1:0] rand_channel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 8'd255;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // primaries, secondaries, black and white at the reset size
  task automatic test_color_extremes();
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
  endtask

  // shrink the width while the column count is well past the new row end
  task automatic test_resize_mid_row();
    set_frame_size(2, 2);
    send_pixel(8'h55, 8'hAA, 8'h55);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h0F, 8'hF0, 8'h3C);
    repeat (4) send_pixel(rand_channel(), rand_channel(), rand_channel());
  endtask

  task automatic test_size_clamp();
    set_frame_size(0, 1);
    repeat (4) send_pixel(rand_channel(), rand_channel(), rand_channel());
    set_frame_size(8191, 4096);
    send_pixel(8'd10, 8'd200, 8'd90);
    send_pixel(8'd250, 8'd3, 8'd128);
  endtask

  task automatic test_odd_width();
    set_frame_size(3, 2);
    repeat (6) send_pixel(rand_channel(), rand_channel(), rand_channel());
  endtask

  task automatic test_random_frames(input int pixel_budget);
    int sent;
    int n;
    int w;
    int h;
    sent = 0;
    while (sent < pixel_budget) begin
      case ($urandom_range(0, 9))
        0: begin
          w = $urandom_range(0, 8191);
          h = $urandom_range(0, 8191);
        end
        1: begin
          w = 2 * $urandom_range(1, 2048);
          h = $urandom_range(2, 16);
        end
        2: begin
          w = 2 * $urandom_range(0, 4) + 1;
          h = $urandom_range(1, 5);
        end
        default: begin
          w = 2 * $urandom_range(1, 8);
          h = $urandom_range(2, 6);
        end
      endcase
      set_frame_size(w, h);
      src_idle  = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      n = $urandom_range(4, 80);
      repeat (n) begin
        send_pixel(rand_channel(), rand_channel(), rand_channel());
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
      sent += n;
    end
  endtask

  // output side: random stall before each result
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      stall = sink_idle ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_yuv.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with nothing pending", beat_index));
      end else begin
        want = pending_yuv.pop_front();
        if (m_axis_tdata[7:0] !== want.luma)
          report_mismatch($sformatf("beat %0d luma %0d, want %0d",
                                    beat_index, m_axis_tdata[7:0], want.luma));
        if (m_axis_tdata[15:8] !== want.chroma_u)
          report_mismatch($sformatf("beat %0d chroma_u %0d, want %0d",
                                    beat_index, m_axis_tdata[15:8], want.chroma_u));
        if (m_axis_tdata[23:16] !== want.chroma_v)
          report_mismatch($sformatf("beat %0d chroma_v %0d, want %0d",
                                    beat_index, m_axis_tdata[23:16], want.chroma_v));
        if (m_axis_tuser !== want.chroma_valid)
          report_mismatch($sformatf("beat %0d chroma_valid %b, want %b",
                                    beat_index, m_axis_tuser, want.chroma_valid));
        if (m_axis_tlast !== want.frame_end)
          report_mismatch($sformatf("beat %0d frame_end %b, want %b",
                                    beat_index, m_axis_tlast, want.frame_end));
      end
      beat_index++;
    end
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    cfg_wen       = 1'b0;
    cfg_index     = REG_IMAGE_WIDTH;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    size_width    = RESET_WIDTH;
    size_height   = RESET_HEIGHT;
    col_pos       = 0;
    row_pos       = 0;
    mismatches    = 0;
    beat_index    = 0;
    src_idle      = 1'b1;
    sink_idle     = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_color_extremes();
    test_resize_mid_row();
    test_size_clamp();
    test_odd_width();
    test_random_frames(1600);

    wait_drained();
    if (pending_yuv.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_yuv.size()));
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rgb2yuv_pkg.sv
rtl/rgb2yuv_front.sv
rtl/rgb2yuv_fifo.sv
rtl/rgb2yuv_back.sv
rtl/rgb_to_yuv420_converter_core.sv
rtl/rgb2yuv_checker.sv
dv/tb_rgb_to_yuv420_converter_core.sv
